[rtl/core/mlr_pkg.sv]
`timescale 1ns / 1ps

package mlr_pkg;

	// Default coordinate width of the endpoints and of the emitted pixels.
	localparam int COORD_BITS_DEF = 12;

	// Octant group of the active line after the endpoints are ordered.
	typedef enum logic [1:0] {
		MODE_X_RISE  = 2'd0,
		MODE_Y_RISE  = 2'd1,
		MODE_X_FALL  = 2'd2,
		MODE_Y_FALL  = 2'd3
	} mode_t;

	// Item function codes.
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	// Control flags produced by the setup and step logic.
	typedef struct packed {
		mode_t mode;
		logic  last;
	} line_ctrl_t;

endpackage

[rtl/core/mlr_if.sv]
`timescale 1ns / 1ps

// Input channel: one item is a start or a step command.
interface mlr_in_if #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic signed [COORD_BITS-1:0] x_start;
	logic signed [COORD_BITS-1:0] y_start;
	logic signed [COORD_BITS-1:0] x_end;
	logic signed [COORD_BITS-1:0] y_end;

	modport source (output valid, func, x_start, y_start, x_end, y_end, input ready);
	modport sink   (input valid, func, x_start, y_start, x_end, y_end, output ready);
endinterface

// Output channel: one item is one pixel result.
interface mlr_out_if #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         pixel_valid;
	logic                         last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_valid, last_pixel, input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_valid, last_pixel, output ready);
endinterface

[rtl/core/mlr_setup.sv]
`timescale 1ns / 1ps

// Line setup: orders the endpoints, picks the mode and the starting decision value.
module mlr_setup #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] x_a,
	input  logic signed [COORD_BITS-1:0] y_a,
	input  logic signed [COORD_BITS-1:0] x_b,
	input  logic signed [COORD_BITS-1:0] y_b,
	output logic signed [COORD_BITS-1:0] cur_x,
	output logic signed [COORD_BITS-1:0] cur_y,
	output logic signed [COORD_BITS-1:0] major_end,
	output logic signed [COORD_BITS:0]   delta_x,
	output logic signed [COORD_BITS:0]   delta_y,
	output logic signed [COORD_BITS+2:0] decision,
	output mlr_pkg::line_ctrl_t          ctrl
);
	localparam int DLW = COORD_BITS + 1;
	localparam int DW  = COORD_BITS + 3;

	logic signed [DLW-1:0] raw_dx;
	logic signed [DLW-1:0] raw_dy;
	logic        [DLW-1:0] abs_dx;
	logic        [DLW-1:0] abs_dy;
	logic                  x_major;
	logic                  swap;
	logic signed [DLW-1:0] half_dx;
	logic signed [DLW-1:0] half_dy;
	logic signed [DW-1:0]  dx_e;
	logic signed [DW-1:0]  dy_e;
	logic signed [DW-1:0]  hdx_e;
	logic signed [DW-1:0]  hdy_e;

	// Raw deltas and their magnitudes pick the major axis.
	always_comb begin
		raw_dx  = {x_b[COORD_BITS-1], x_b} - {x_a[COORD_BITS-1], x_a};
		raw_dy  = {y_b[COORD_BITS-1], y_b} - {y_a[COORD_BITS-1], y_a};
		abs_dx  = raw_dx[DLW-1] ? DLW'(-raw_dx) : DLW'(raw_dx);
		abs_dy  = raw_dy[DLW-1] ? DLW'(-raw_dy) : DLW'(raw_dy);
		x_major = (abs_dy <= abs_dx);
		swap    = x_major ? (x_a > x_b) : (y_a > y_b);
	end

	// Ordered endpoints and deltas along an upward major axis.
	always_comb begin
		cur_x     = swap ? x_b : x_a;
		cur_y     = swap ? y_b : y_a;
		delta_x   = swap ? DLW'(-raw_dx) : raw_dx;
		delta_y   = swap ? DLW'(-raw_dy) : raw_dy;
		major_end = x_major ? (swap ? x_a : x_b) : (swap ? y_a : y_b);
		// The halved delta is the major one, which is never negative here.
		half_dx   = delta_x >>> 1;
		half_dy   = delta_y >>> 1;
		dx_e      = {{(DW-DLW){delta_x[DLW-1]}}, delta_x};
		dy_e      = {{(DW-DLW){delta_y[DLW-1]}}, delta_y};
		hdx_e     = {{(DW-DLW){half_dx[DLW-1]}}, half_dx};
		hdy_e     = {{(DW-DLW){half_dy[DLW-1]}}, half_dy};
	end

	// Mode and starting decision value.
	always_comb begin
		if (x_major) begin
			ctrl.last = (cur_x == major_end);
			if (!delta_y[DLW-1]) begin
				ctrl.mode = mlr_pkg::MODE_X_RISE;
				decision  = dy_e - hdx_e;
			end else begin
				ctrl.mode = mlr_pkg::MODE_X_FALL;
				decision  = dy_e + hdx_e;
			end
		end else begin
			ctrl.last = (cur_y == major_end);
			if (!delta_x[DLW-1]) begin
				ctrl.mode = mlr_pkg::MODE_Y_RISE;
				decision  = hdy_e - dx_e;
			end else begin
				ctrl.mode = mlr_pkg::MODE_Y_FALL;
				decision  = -hdy_e - dx_e;
			end
		end
	end

endmodule

[rtl/core/mlr_step.sv]
`timescale 1ns / 1ps

// One midpoint step: decision test, position and decision update, end test.
module mlr_step #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] cur_x,
	input  logic signed [COORD_BITS-1:0] cur_y,
	input  logic signed [COORD_BITS-1:0] major_end,
	input  logic signed [COORD_BITS:0]   delta_x,
	input  logic signed [COORD_BITS:0]   delta_y,
	input  logic signed [COORD_BITS+2:0] decision,
	input  mlr_pkg::mode_t               mode,
	output logic signed [COORD_BITS-1:0] next_x,
	output logic signed [COORD_BITS-1:0] next_y,
	output logic signed [COORD_BITS+2:0] next_decision,
	output mlr_pkg::line_ctrl_t          ctrl
);
	localparam int DLW = COORD_BITS + 1;
	localparam int DW  = COORD_BITS + 3;

	logic signed [DW-1:0] dx_e;
	logic signed [DW-1:0] dy_e;

	always_comb begin
		dx_e = {{(DW-DLW){delta_x[DLW-1]}}, delta_x};
		dy_e = {{(DW-DLW){delta_y[DLW-1]}}, delta_y};
	end

	// Per-mode decision test and update.
	always_comb begin
		next_x        = cur_x;
		next_y        = cur_y;
		next_decision = decision;
		case (mode)
			mlr_pkg::MODE_X_RISE: begin
				if (decision[DW-1]) begin
					next_decision = decision + dy_e;
				end else begin
					next_decision = decision + dy_e - dx_e;
					next_y        = cur_y + COORD_BITS'(1);
				end
				next_x = cur_x + COORD_BITS'(1);
			end
			mlr_pkg::MODE_Y_RISE: begin
				if (decision <= 0) begin
					next_decision = decision + dy_e - dx_e;
					next_x        = cur_x + COORD_BITS'(1);
				end else begin
					next_decision = decision - dx_e;
				end
				next_y = cur_y + COORD_BITS'(1);
			end
			mlr_pkg::MODE_X_FALL: begin
				if (decision <= 0) begin
					next_decision = decision + dy_e + dx_e;
					next_y        = cur_y - COORD_BITS'(1);
				end else begin
					next_decision = decision + dy_e;
				end
				next_x = cur_x + COORD_BITS'(1);
			end
			mlr_pkg::MODE_Y_FALL: begin
				if (!decision[DW-1]) begin
					next_decision = decision - dy_e - dx_e;
					next_x        = cur_x - COORD_BITS'(1);
				end else begin
					next_decision = decision - dx_e;
				end
				next_y = cur_y + COORD_BITS'(1);
			end
			default: begin
				next_decision = decision;
			end
		endcase
	end

	// The line ends when the major coordinate reaches its endpoint.
	always_comb begin
		ctrl.mode = mode;
		ctrl.last = mode[0] ? (next_y >= major_end) : (next_x >= major_end);
	end

endmodule

[rtl/core/midpoint_line_rasterizer.sv]
`timescale 1ns / 1ps
// Midpoint line rasterizer: one pixel result for every start or step item.
// An accepted item is held in the input register; when the result register is
// free, the setup/step logic writes its pixel into the result register.
// Throughput: 1 item per cycle while the output channel takes results, set by
// the setup/step logic that updates the line state between the two registers.
// Reset (arst_n low, asynchronous): both stages empty, line idle, state zero.
module midpoint_line_rasterizer #(
	parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	mlr_in_if.sink         in_ch,
	mlr_out_if.source      out_ch
);
	localparam int DLW = COORD_BITS + 1;
	localparam int DW  = COORD_BITS + 3;

	// Input stage.
	logic                         valid_s1;
	logic                         func_s1;
	logic signed [COORD_BITS-1:0] x_start_s1;
	logic signed [COORD_BITS-1:0] y_start_s1;
	logic signed [COORD_BITS-1:0] x_end_s1;
	logic signed [COORD_BITS-1:0] y_end_s1;

	// Line state.
	logic signed [COORD_BITS-1:0] cur_x_q;
	logic signed [COORD_BITS-1:0] cur_y_q;
	logic signed [COORD_BITS-1:0] major_end_q;
	logic signed [DW-1:0]         decision_q;
	logic signed [DLW-1:0]        delta_x_q;
	logic signed [DLW-1:0]        delta_y_q;
	mlr_pkg::mode_t               mode_q;
	logic                         active_q;

	// Result register.
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] pixel_x_q;
	logic signed [COORD_BITS-1:0] pixel_y_q;
	logic                         pixel_valid_q;
	logic                         last_pixel_q;

	// Setup and step results.
	logic signed [COORD_BITS-1:0] su_x;
	logic signed [COORD_BITS-1:0] su_y;
	logic signed [COORD_BITS-1:0] su_end;
	logic signed [DLW-1:0]        su_dx;
	logic signed [DLW-1:0]        su_dy;
	logic signed [DW-1:0]         su_dec;
	mlr_pkg::line_ctrl_t          su_ctrl;
	logic signed [COORD_BITS-1:0] st_x;
	logic signed [COORD_BITS-1:0] st_y;
	logic signed [DW-1:0]         st_dec;
	mlr_pkg::line_ctrl_t          st_ctrl;

	logic advance;
	logic in_fire;
	logic work;

	mlr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.x_a       (x_start_s1),
		.y_a       (y_start_s1),
		.x_b       (x_end_s1),
		.y_b       (y_end_s1),
		.cur_x     (su_x),
		.cur_y     (su_y),
		.major_end (su_end),
		.delta_x   (su_dx),
		.delta_y   (su_dy),
		.decision  (su_dec),
		.ctrl      (su_ctrl)
	);

	mlr_step #(.COORD_BITS(COORD_BITS)) u_step (
		.cur_x         (cur_x_q),
		.cur_y         (cur_y_q),
		.major_end     (major_end_q),
		.delta_x       (delta_x_q),
		.delta_y       (delta_y_q),
		.decision      (decision_q),
		.mode          (mode_q),
		.next_x        (st_x),
		.next_y        (st_y),
		.next_decision (st_dec),
		.ctrl          (st_ctrl)
	);

	// Handshake: the input stage moves on whenever the result register is free.
	always_comb begin
		advance      = !out_valid_q || out_ch.ready;
		in_ch.ready  = !valid_s1 || advance;
		in_fire      = in_ch.valid && in_ch.ready;
		work         = valid_s1 && advance;
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1    <= in_ch.func;
			x_start_s1 <= in_ch.x_start;
			y_start_s1 <= in_ch.y_start;
			x_end_s1   <= in_ch.x_end;
			y_end_s1   <= in_ch.y_end;
		end
	end

	// Line state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			major_end_q <= '0;
			decision_q  <= '0;
			delta_x_q   <= '0;
			delta_y_q   <= '0;
			mode_q      <= mlr_pkg::MODE_X_RISE;
			active_q    <= 1'b0;
		end else if (work) begin
			if (func_s1 == mlr_pkg::FUNC_START) begin
				cur_x_q     <= su_x;
				cur_y_q     <= su_y;
				major_end_q <= su_end;
				decision_q  <= su_dec;
				delta_x_q   <= su_dx;
				delta_y_q   <= su_dy;
				mode_q      <= su_ctrl.mode;
				active_q    <= !su_ctrl.last;
			end else if (active_q) begin
				cur_x_q    <= st_x;
				cur_y_q    <= st_y;
				decision_q <= st_dec;
				active_q   <= !st_ctrl.last;
			end
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (work) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload; a step on an idle line gives an empty item.
	always_ff @(posedge clk) begin
		if (work) begin
			if (func_s1 == mlr_pkg::FUNC_START) begin
				pixel_x_q     <= su_x;
				pixel_y_q     <= su_y;
				pixel_valid_q <= 1'b1;
				last_pixel_q  <= su_ctrl.last;
			end else if (active_q) begin
				pixel_x_q     <= st_x;
				pixel_y_q     <= st_y;
				pixel_valid_q <= 1'b1;
				last_pixel_q  <= st_ctrl.last;
			end else begin
				pixel_x_q     <= '0;
				pixel_y_q     <= '0;
				pixel_valid_q <= 1'b0;
				last_pixel_q  <= 1'b0;
			end
		end
	end

	// Output channel.
	always_comb begin
		out_ch.valid       = out_valid_q;
		out_ch.pixel_x     = pixel_x_q;
		out_ch.pixel_y     = pixel_y_q;
		out_ch.pixel_valid = pixel_valid_q;
		out_ch.last_pixel  = last_pixel_q;
	end

endmodule

[tb/tb_midpoint_line_rasterizer.sv]
`timescale 1ns / 1ps

module tb_midpoint_line_rasterizer;

	localparam int CB = 12;

	// One command item on the input channel.
	typedef struct {
		logic                 func;
		logic signed [CB-1:0] x_start;
		logic signed [CB-1:0] y_start;
		logic signed [CB-1:0] x_end;
		logic signed [CB-1:0] y_end;
	} cmd_t;

	// One pixel result on the output channel.
	typedef struct {
		logic signed [CB-1:0] pixel_x;
		logic signed [CB-1:0] pixel_y;
		logic                 pixel_valid;
		logic                 last_pixel;
	} pixel_t;

	// Tracks the line state of the rasterizer and checks each pixel in order.
	class pixel_scoreboard;
		int              cur_x;
		int              cur_y;
		int              major_stop;
		int              decision;
		int              dx;
		int              dy;
		mlr_pkg::mode_t  mode;
		bit              drawing;
		pixel_t          expected_pixels[$];
		int              errors;

		function new();
			cur_x = 0;
			cur_y = 0;
			major_stop = 0;
			decision = 0;
			dx = 0;
			dy = 0;
			mode = mlr_pkg::MODE_X_RISE;
			drawing = 1'b0;
			errors = 0;
		endfunction

		function int mag(int v);
			return (v < 0) ? -v : v;
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		// Works out the pixel that an accepted command produces.
		function void predict_pixel(cmd_t c);
			int     xa;
			int     ya;
			int     xb;
			int     yb;
			int     t;
			bit     xmajor;
			bit     fin;
			pixel_t p;

			if (c.func == mlr_pkg::FUNC_START) begin
				xa = c.x_start;
				ya = c.y_start;
				xb = c.x_end;
				yb = c.y_end;
				xmajor = mag(yb - ya) <= mag(xb - xa);
				// Order the endpoints so that the major axis runs upward.
				if ((xmajor && xa > xb) || (!xmajor && ya > yb)) begin
					t = xa; xa = xb; xb = t;
					t = ya; ya = yb; yb = t;
				end
				dx = xb - xa;
				dy = yb - ya;
				cur_x = xa;
				cur_y = ya;
				if (xmajor) begin
					major_stop = xb;
					if (dy >= 0) begin
						mode = mlr_pkg::MODE_X_RISE;
						decision = dy - dx / 2;
					end else begin
						mode = mlr_pkg::MODE_X_FALL;
						decision = dy + dx / 2;
					end
					fin = (cur_x == major_stop);
				end else begin
					major_stop = yb;
					if (dx >= 0) begin
						mode = mlr_pkg::MODE_Y_RISE;
						decision = dy / 2 - dx;
					end else begin
						mode = mlr_pkg::MODE_Y_FALL;
						decision = -(dy / 2) - dx;
					end
					fin = (cur_y == major_stop);
				end
				drawing = !fin;
			end else begin
				// A step with no line in progress gives an empty result.
				if (!drawing) begin
					p.pixel_x = '0;
					p.pixel_y = '0;
					p.pixel_valid = 1'b0;
					p.last_pixel = 1'b0;
					expected_pixels.push_back(p);
					return;
				end
				case (mode)
					mlr_pkg::MODE_X_RISE: begin
						if (decision < 0) begin
							decision += dy;
						end else begin
							decision += dy - dx;
							cur_y++;
						end
						cur_x++;
					end
					mlr_pkg::MODE_Y_RISE: begin
						if (decision <= 0) begin
							decision += dy - dx;
							cur_x++;
						end else begin
							decision -= dx;
						end
						cur_y++;
					end
					mlr_pkg::MODE_X_FALL: begin
						if (decision <= 0) begin
							decision += dy + dx;
							cur_y--;
						end else begin
							decision += dy;
						end
						cur_x++;
					end
					default: begin
						if (decision >= 0) begin
							decision += -dy - dx;
							cur_x--;
						end else begin
							decision -= dx;
						end
						cur_y++;
					end
				endcase
				if (mode == mlr_pkg::MODE_X_RISE || mode == mlr_pkg::MODE_X_FALL)
					fin = (cur_x >= major_stop);
				else
					fin = (cur_y >= major_stop);
				if (fin)
					drawing = 1'b0;
			end
			p.pixel_x = cur_x[CB-1:0];
			p.pixel_y = cur_y[CB-1:0];
			p.pixel_valid = 1'b1;
			p.last_pixel = fin;
			expected_pixels.push_back(p);
		endfunction

		// Compares one received pixel with the oldest prediction.
		function void check_pixel(pixel_t got);
			pixel_t exp_p;

			if (expected_pixels.size() == 0) begin
				$error("pixel received with nothing predicted: x=%0d y=%0d",
					got.pixel_x, got.pixel_y);
				errors++;
				return;
			end
			exp_p = expected_pixels.pop_front();
			if (got.pixel_x !== exp_p.pixel_x) begin
				$error("pixel_x: expected %0d, got %0d", exp_p.pixel_x, got.pixel_x);
				errors++;
			end
			if (got.pixel_y !== exp_p.pixel_y) begin
				$error("pixel_y: expected %0d, got %0d", exp_p.pixel_y, got.pixel_y);
				errors++;
			end
			if (got.pixel_valid !== exp_p.pixel_valid) begin
				$error("pixel_valid: expected %0d, got %0d",
					exp_p.pixel_valid, got.pixel_valid);
				errors++;
			end
			if (got.last_pixel !== exp_p.last_pixel) begin
				$error("last_pixel: expected %0d, got %0d",
					exp_p.last_pixel, got.last_pixel);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mlr_in_if  #(.COORD_BITS(CB)) in_ch ();
	mlr_out_if #(.COORD_BITS(CB)) out_ch ();

	midpoint_line_rasterizer #(.COORD_BITS(CB)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	pixel_scoreboard chk;
	int idle_pct;
	int items_sent;
	int rx_hold;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Output stalls come in random bursts while idling is enabled.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (rx_hold > 0) begin
			out_ch.ready <= 1'b0;
			rx_hold--;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			rx_hold = $urandom_range(1, 15) - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Every accepted pixel goes to the scoreboard.
	always @(posedge clk) begin
		pixel_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.pixel_x = out_ch.pixel_x;
			got.pixel_y = out_ch.pixel_y;
			got.pixel_valid = out_ch.pixel_valid;
			got.last_pixel = out_ch.last_pixel;
			chk.check_pixel(got);
		end
	end

	function automatic cmd_t start_cmd(int xs, int ys, int xe, int ye);
		cmd_t c;
		c.func = mlr_pkg::FUNC_START;
		c.x_start = xs[CB-1:0];
		c.y_start = ys[CB-1:0];
		c.x_end = xe[CB-1:0];
		c.y_end = ye[CB-1:0];
		return c;
	endfunction

	// Step commands carry random coordinates, which the block must ignore.
	function automatic cmd_t step_cmd();
		cmd_t c;
		c.func = mlr_pkg::FUNC_STEP;
		c.x_start = CB'($urandom_range(0, 4095));
		c.y_start = CB'($urandom_range(0, 4095));
		c.x_end = CB'($urandom_range(0, 4095));
		c.y_end = CB'($urandom_range(0, 4095));
		return c;
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 19))
			0: return -2048;
			1: return 2047;
			default: return int'($urandom_range(0, 4095)) - 2048;
		endcase
	endfunction

	// A point within span of base that stays inside the coordinate range.
	function automatic int near(int base, int span);
		int off;
		int p;
		off = $urandom_range(0, span);
		if ($urandom_range(0, 1))
			off = -off;
		p = base + off;
		if (p < -2048 || p > 2047)
			p = base - off;
		return p;
	endfunction

	// Drives one item, with an optional gap first, and waits until it is taken.
	task automatic send_item(cmd_t c);
		int gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 15);
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.func <= c.func;
		in_ch.x_start <= c.x_start;
		in_ch.y_start <= c.y_start;
		in_ch.x_end <= c.x_end;
		in_ch.y_end <= c.y_end;
		do @(posedge clk); while (!in_ch.ready);
		chk.predict_pixel(c);
		items_sent++;
	endtask

	task automatic draw_line(int xs, int ys, int xe, int ye, int steps);
		send_item(start_cmd(xs, ys, xe, ye));
		repeat (steps) send_item(step_cmd());
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while (chk.pending() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// Main sequence: reset, directed lines, then random lines.
	initial begin
		int   kind;
		int   xs;
		int   ys;
		int   xe;
		int   ye;
		int   steps;
		int   lines;
		cmd_t c;

		chk = new();
		idle_pct = 0;
		items_sent = 0;
		rx_hold = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.func = mlr_pkg::FUNC_START;
		in_ch.x_start = '0;
		in_ch.y_start = '0;
		in_ch.x_end = '0;
		in_ch.y_end = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: idle step, single point, each mode, equal slopes, extremes.
		idle_pct = 20;
		c.func = mlr_pkg::FUNC_STEP;
		c.x_start = 12'sh7ff;
		c.y_start = 12'sh800;
		c.x_end = 12'shfff;
		c.y_end = 12'sh000;
		send_item(c);
		draw_line(2047, 2047, 2047, 2047, 0);
		draw_line(0, 0, 3, 1, 3);
		draw_line(1, 3, 0, 0, 3);
		draw_line(0, 2, 3, 0, 3);
		draw_line(2, 0, 0, 3, 3);
		draw_line(2, -2, 0, 0, 2);
		draw_line(-2048, -2048, 2047, 2047, 2);
		// A new start abandons the line in progress.
		draw_line(2047, -2048, -2048, 2047, 1);

		// Hold the sender until every directed pixel is back.
		@(negedge clk);
		in_ch.valid <= 1'b0;
		wait_drained();

		// Random lines, mostly short and complete, with noise mixed in.
		lines = 0;
		while (items_sent < 1800) begin
			if (items_sent >= 1500)
				idle_pct = 0;
			else if (lines % 10 == 0)
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 25;
				endcase
			lines++;
			kind = $urandom_range(0, 99);
			if (kind < 5) begin
				repeat ($urandom_range(1, 3)) send_item(step_cmd());
			end else if (kind < 9) begin
				xs = rand_coord();
				ys = rand_coord();
				xe = rand_coord();
				ye = rand_coord();
				draw_line(xs, ys, xe, ye, $urandom_range(20, 120));
			end else begin
				xs = rand_coord();
				ys = rand_coord();
				if ($urandom_range(0, 9) == 0) begin
					xe = near(xs, 200);
					ye = near(ys, 200);
				end else begin
					xe = near(xs, 24);
					ye = near(ys, 24);
				end
				case ($urandom_range(0, 7))
					0: xe = xs;
					1: ye = ys;
					default: ;
				endcase
				steps = chk.mag(xe - xs);
				if (chk.mag(ye - ys) > steps)
					steps = chk.mag(ye - ys);
				// Some lines are cut short, some run past their end.
				case ($urandom_range(0, 9))
					0: steps = $urandom_range(0, steps);
					1: steps += $urandom_range(1, 2);
					default: ;
				endcase
				draw_line(xs, ys, xe, ye, steps);
			end
		end

		@(negedge clk);
		in_ch.valid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		if (chk.pending() != 0) begin
			$error("%0d predicted pixels never arrived", chk.pending());
			chk.errors++;
		end
		if (chk.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
rtl/core/mlr_pkg.sv
rtl/core/mlr_if.sv
rtl/core/mlr_setup.sv
rtl/core/mlr_step.sv
rtl/core/midpoint_line_rasterizer.sv
tb/tb_midpoint_line_rasterizer.sv
